>>> hdl/olws_pkg.sv
package olws_pkg;

	typedef enum logic [1:0] {
		FUNC_PUSH      = 2'd0,
		FUNC_POP       = 2'd1,
		FUNC_FIND      = 2'd2,
		FUNC_REMOVE_AT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// per-cell controls from the list control to one cell
	typedef struct packed {
		logic load_prev;  // take the neighbor toward the front (push)
		logic load_next;  // take the neighbor toward the back (close up)
		logic capture;    // register the compare against the key
	} cell_ctrl_t;

endpackage

>>> hdl/olws_cell.sv
module olws_cell #(
	parameter int ITEM_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  olws_pkg::cell_ctrl_t   ctrl,
	input  logic [ITEM_WIDTH-1:0]  prev_data,
	input  logic                   prev_valid,
	input  logic [ITEM_WIDTH-1:0]  next_data,
	input  logic                   next_valid,
	input  logic [ITEM_WIDTH-1:0]  key,
	output logic [ITEM_WIDTH-1:0]  data,
	output logic                   valid,
	output logic                   hit
);

	logic [ITEM_WIDTH-1:0] data_q;
	logic                  valid_q;
	logic                  hit_s1;

	// payload: no reset
	always_ff @(posedge clk) begin
		if (ctrl.load_prev) begin
			data_q <= prev_data;
		end else if (ctrl.load_next) begin
			data_q <= next_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			if (ctrl.load_prev) begin
				valid_q <= prev_valid;
			end else if (ctrl.load_next) begin
				valid_q <= next_valid;
			end
			// compare on the contents seen before this item's update
			if (ctrl.capture) begin
				hit_s1 <= valid_q && (data_q == key);
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign hit   = hit_s1;

endmodule

>>> hdl/ordered_list_with_search.sv
// Result: the start edge loads stage 1 (pending_s1 and the cells' hit row); stage 2 then registers
// the done strobe and the result, which stay on the ports for one cycle.
// Issue: busy holds off a new item while one is in stage 1, as the registered hit row of the
// cell chain feeding the first-hit encoder must be read before another compare overwrites it.
// Reset (arst_n low) empties the list and drops any item in flight; cell payloads are
// not cleared. The receiver cannot stall: each result shows for one cycle only.
module ordered_list_with_search #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [3:0]  found_position,
	output logic [31:0] front_item,
	output logic [4:0]  item_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	// chain wiring: index 0 is the front of the list
	olws_pkg::cell_ctrl_t  cell_ctrl [CAPACITY];
	logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	logic [CAPACITY-1:0]   cell_hit;

	logic [CW-1:0]         count_q;
	logic                  pending_s1;
	olws_pkg::func_t       func_s1;
	olws_pkg::status_t     status_s1;

	logic                  done_q;
	olws_pkg::status_t     status_q;
	logic                  found_q;
	logic [3:0]            found_pos_q;
	logic [31:0]           front_q;
	logic [4:0]            count_out_q;

	logic                  accept;
	logic [ITEM_WIDTH-1:0] key;
	olws_pkg::func_t       func_in;
	logic                  is_empty;
	logic                  push_ok;
	logic                  pop_ok;
	logic                  rem_ok;
	olws_pkg::status_t     status_d;
	logic                  any_hit;
	logic [IW-1:0]         first_hit;

	assign accept   = start && !busy;
	assign busy     = pending_s1;
	assign key      = ITEM_WIDTH'(value);
	assign func_in  = olws_pkg::func_t'(func);
	assign is_empty = (count_q == '0);

	// decide the outcome of the item from the count and, for remove-at, the position
	always_comb begin
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		rem_ok   = 1'b0;
		status_d = olws_pkg::ST_OK;
		unique case (func_in)
			olws_pkg::FUNC_PUSH: begin
				if (count_q == CW'(CAPACITY)) begin
					status_d = olws_pkg::ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			olws_pkg::FUNC_POP: begin
				if (is_empty) begin
					status_d = olws_pkg::ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			olws_pkg::FUNC_FIND: begin
				status_d = olws_pkg::ST_OK;
			end
			olws_pkg::FUNC_REMOVE_AT: begin
				if (is_empty) begin
					status_d = olws_pkg::ST_EMPTY;
				end else if (32'(position) >= 32'(count_q)) begin
					status_d = olws_pkg::ST_RANGE;
				end else begin
					rem_ok = 1'b1;
				end
			end
			default: status_d = olws_pkg::ST_OK;
		endcase
	end

	// the row of cells: push shifts toward the back, removal closes up toward the front
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] prev_data;
		logic                  prev_valid;
		logic [ITEM_WIDTH-1:0] next_data;
		logic                  next_valid;

		if (i == 0) begin : g_front
			assign prev_data  = key;
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_data  = cell_data[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign next_data  = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_data  = cell_data[i+1];
			assign next_valid = cell_valid[i+1];
		end

		assign cell_ctrl[i].load_prev = accept && push_ok;
		assign cell_ctrl[i].load_next = accept &&
			(pop_ok || (rem_ok && (32'(i) >= 32'(position))));
		assign cell_ctrl[i].capture   = accept;

		olws_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl[i]),
			.prev_data (prev_data),
			.prev_valid(prev_valid),
			.next_data (next_data),
			.next_valid(next_valid),
			.key       (key),
			.data      (cell_data[i]),
			.valid     (cell_valid[i]),
			.hit       (cell_hit[i])
		);
	end

	// first registered hit wins: scan from the back so the lowest index stays
	always_comb begin
		first_hit = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_hit[i]) begin
				first_hit = IW'(i);
			end
		end
	end
	assign any_hit = |cell_hit;

	// stage 1: count update and the item's status; cells update in the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pending_s1 <= 1'b0;
			func_s1    <= olws_pkg::FUNC_PUSH;
			status_s1  <= olws_pkg::ST_OK;
		end else begin
			pending_s1 <= accept;
			if (accept) begin
				func_s1   <= func_in;
				status_s1 <= status_d;
				if (push_ok) begin
					count_q <= count_q + CW'(1);
				end else if (pop_ok || rem_ok) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// stage 2: encode the hit and register the result with a one-cycle done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pending_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pending_s1) begin
			status_q    <= status_s1;
			found_q     <= (func_s1 == olws_pkg::FUNC_FIND) && any_hit;
			found_pos_q <= ((func_s1 == olws_pkg::FUNC_FIND) && any_hit) ?
				4'(first_hit) : 4'd0;
			front_q     <= cell_valid[0] ? 32'(cell_data[0]) : 32'd0;
			count_out_q <= 5'(count_q);
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found          = found_q;
	assign found_position = found_pos_q;
	assign front_item     = front_q;
	assign item_count     = count_out_q;

endmodule

>>> test/ordered_list_with_search_test.sv
module ordered_list_with_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import olws_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_ITEMS = 1950;
	localparam int QUIET_TAIL = 150;     // items at the end driven with no gaps

	// one pending operation; a marker entry makes the driver wait for the list to go quiet
	typedef struct {
		bit          drain;
		func_t       fn;
		logic [31:0] val;
		logic [3:0]  pos;
	} list_op_t;

	// what the block should report for one operation
	typedef struct {
		status_t     st;
		logic        hit;
		logic [3:0]  hit_pos;
		logic [31:0] front;
		logic [4:0]  len;
	} list_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	func_t       func = FUNC_PUSH;
	logic [31:0] value = '0;
	logic [3:0]  position = '0;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [3:0]  found_position;
	logic [31:0] front_item;
	logic [4:0]  item_count;

	ordered_list_with_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.value          (value),
		.position       (position),
		.done           (done),
		.status         (status),
		.found          (found),
		.found_position (found_position),
		.front_item     (front_item),
		.item_count     (item_count)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the list: entry 0 is the front.
	// ------------------------------------------------------------------
	logic [31:0] shadow_items [LIST_DEPTH];
	int          shadow_len = 0;

	list_op_t      op_q [$];       // items waiting to be driven
	list_outcome_t outcome_q [$];  // predictions waiting for their result

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_hits = 0;
	int empty_hits = 0;
	int range_hits = 0;
	int find_hits = 0;
	int peak_len = 0;

	// close the gap left by removing entry 'from'
	function automatic void close_gap(int from);
		int i;
		for (i = from; i + 1 < shadow_len; i++)
			shadow_items[i] = shadow_items[i + 1];
		shadow_len--;
	endfunction

	// apply one operation to the shadow list and return the outcome it implies
	function automatic list_outcome_t apply_list_op(func_t fn, logic [31:0] val,
			logic [3:0] pos);
		list_outcome_t r;
		int i;
		r.st = ST_OK;
		r.hit = 1'b0;
		r.hit_pos = '0;
		case (fn)
			FUNC_PUSH: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					for (i = shadow_len; i > 0; i--)
						shadow_items[i] = shadow_items[i - 1];
					shadow_items[0] = val;
					shadow_len++;
				end
			end
			FUNC_POP: begin
				if (shadow_len == 0)
					r.st = ST_EMPTY;
				else
					close_gap(0);
			end
			FUNC_FIND: begin
				// first match wins, so later matches are ignored once one is found
				for (i = 0; i < shadow_len; i++) begin
					if (!r.hit && shadow_items[i] == val) begin
						r.hit = 1'b1;
						r.hit_pos = 4'(i);
					end
				end
			end
			default: begin
				if (shadow_len == 0)
					r.st = ST_EMPTY;
				else if (int'(pos) >= shadow_len)
					r.st = ST_RANGE;
				else
					close_gap(int'(pos));
			end
		endcase
		r.front = (shadow_len > 0) ? shadow_items[0] : 32'd0;
		r.len = 5'(shadow_len);
		return r;
	endfunction

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	// ------------------------------------------------------------------
	// Driver: change inputs on the falling edge only.
	// ------------------------------------------------------------------
	bit item_taken = 1'b0;   // set at the rising edge that accepted the item on the ports
	bit draining = 1'b0;
	int gap_left = 0;

	always @(negedge clk) begin
		list_op_t op;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			// block was busy: hold the item on the ports
		end else if (draining && outcome_q.size() != 0) begin
			start <= 1'b0;
		end else if (gap_left != 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (op_q.size() == 0) begin
			start <= 1'b0;
		end else if (op_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
			// open a gap with start low, this one included
			gap_left = $urandom_range(0, 12);
			start <= 1'b0;
		end else begin
			draining = 1'b0;
			op = op_q.pop_front();
			if (op.drain) begin
				draining = 1'b1;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				func <= op.fn;
				value <= op.val;
				position <= op.pos;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample on the rising edge. Check a result against the oldest
	// prediction first, then predict for an item accepted at this same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		list_outcome_t want;
		list_outcome_t got;
		if (arst_n) begin
			if (done === 1'b1) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: result with no item outstanding, expected none, actual %0h",
						$time, item_count);
				end else begin
					want = outcome_q.pop_front();
					got.st = status_t'(status);
					got.hit = found;
					got.hit_pos = found_position;
					got.front = front_item;
					got.len = item_count;
					if (got.st !== want.st)
						report_field("status", 32'(want.st), 32'(status));
					if (got.hit !== want.hit)
						report_field("found", 32'(want.hit), 32'(found));
					if (got.hit_pos !== want.hit_pos)
						report_field("found_position", 32'(want.hit_pos), 32'(found_position));
					if (got.front !== want.front)
						report_field("front_item", want.front, front_item);
					if (got.len !== want.len)
						report_field("item_count", 32'(want.len), 32'(item_count));
				end
			end
			item_taken = start && !busy;
			if (item_taken) begin
				want = apply_list_op(func, value, position);
				outcome_q.push_back(want);
				items_sent++;
				if (want.st == ST_FULL) full_hits++;
				if (want.st == ST_EMPTY) empty_hits++;
				if (want.st == ST_RANGE) range_hits++;
				if (want.hit) find_hits++;
				if (shadow_len > peak_len) peak_len = shadow_len;
			end
		end else begin
			item_taken = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	task automatic add_op(func_t fn, logic [31:0] val, logic [3:0] pos);
		list_op_t op;
		op.drain = 1'b0;
		op.fn = fn;
		op.val = val;
		op.pos = pos;
		op_q.push_back(op);
	endtask

	task automatic add_drain();
		list_op_t op;
		op.drain = 1'b1;
		op.fn = FUNC_FIND;
		op.val = '0;
		op.pos = '0;
		op_q.push_back(op);
	endtask

	initial begin
		logic [31:0] pool [8];
		int n;
		int k;
		int mode;
		int roll;
		int push_lim;
		int pop_lim;
		int find_lim;
		logic [31:0] v;

		// directed: every operation on an empty list
		add_op(FUNC_FIND, 32'hFFFF_FFFF, 4'd0);
		add_op(FUNC_POP, 32'h0, 4'd0);
		add_op(FUNC_REMOVE_AT, 32'h0, 4'd0);
		add_op(FUNC_REMOVE_AT, 32'hFFFF_FFFF, 4'd15);
		// fill to capacity; all ones ends up at the back, zero at the front
		add_op(FUNC_PUSH, 32'hFFFF_FFFF, 4'd15);
		for (k = 1; k < LIST_DEPTH - 1; k++)
			add_op(FUNC_PUSH, 32'h1000 + k, 4'(k));
		add_op(FUNC_PUSH, 32'h0, 4'd0);
		add_op(FUNC_PUSH, 32'h5, 4'd0);               // list full
		add_op(FUNC_FIND, 32'hFFFF_FFFF, 4'd0);       // hit at the last position
		add_op(FUNC_FIND, 32'h0, 4'd0);               // hit at the front
		add_op(FUNC_FIND, 32'h0000_0FFF, 4'd0);       // miss
		add_op(FUNC_REMOVE_AT, 32'h0, 4'd15);         // remove the back entry
		add_op(FUNC_REMOVE_AT, 32'h0, 4'd15);         // now beyond the count
		add_op(FUNC_REMOVE_AT, 32'h0, 4'd7);          // close up the middle
		add_op(FUNC_POP, 32'h0, 4'd0);
		// let every result come back before the random part
		add_drain();

		// random part: phases that lean toward filling, emptying or neither, with
		// values drawn from a small pool half the time so finds hit and repeat
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 120 == 0) begin
				mode = $urandom_range(0, 2);
				pool[0] = 32'h0;
				pool[1] = 32'hFFFF_FFFF;
				for (k = 2; k < 8; k++)
					pool[k] = $urandom();
			end
			if (n == 700 || n == 1400)
				add_drain();
			case (mode)
				0: begin push_lim = 55; pop_lim = 65; find_lim = 85; end
				1: begin push_lim = 20; pop_lim = 50; find_lim = 65; end
				default: begin push_lim = 32; pop_lim = 50; find_lim = 75; end
			endcase
			roll = $urandom_range(0, 99);
			v = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom();
			if (roll < push_lim)
				add_op(FUNC_PUSH, v, 4'($urandom_range(0, 15)));
			else if (roll < pop_lim)
				add_op(FUNC_POP, v, 4'($urandom_range(0, 15)));
			else if (roll < find_lim)
				add_op(FUNC_FIND, v, 4'($urandom_range(0, 15)));
			else
				add_op(FUNC_REMOVE_AT, v, 4'($urandom_range(0, 15)));
		end

		// hold reset low, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last item to leave the ports, then for every result
		while (op_q.size() != 0 || start || draining) @(negedge clk);
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d items, checked %0d results; list reached %0d entries.",
			items_sent, results_seen, peak_len);
		$display("Full pushes %0d, empty removals %0d, out-of-range removals %0d, find hits %0d.",
			full_hits, empty_hits, range_hits, find_hits);
		if (errors == 0)
			$display("ordered_list_with_search test passed");
		else
			$display("ordered_list_with_search test failed");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#5ms;
		$display("ordered_list_with_search test failed");
		$finish;
	end

endmodule
